[hw/rtl/pfla_pkg.sv]
package pfla_pkg;

  localparam int PAGE_FIELD_W = 12;
  localparam int SEL_FIELD_W  = 2;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_BAD_PAGE = 2'd2
  } status_t;

endpackage

[hw/rtl/pfla_link_mem.sv]
module pfla_link_mem #(
  parameter int DEPTH = 16384,
  parameter int AW    = 14,
  parameter int DW    = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/pfla_fill_unit.sv]
module pfla_fill_unit #(
  parameter int TABLES    = 4,
  parameter int MAX_PAGES = 4096
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [((TABLES > 1) ? $clog2(TABLES) : 1)-1:0] tbl,
  input  logic [$clog2(MAX_PAGES)-1:0]          first,
  input  logic [$clog2(MAX_PAGES)-1:0]          last,
  output logic                                 busy,
  output logic                                 done,
  output logic                                 we,
  output logic [$clog2(TABLES*MAX_PAGES)-1:0]  waddr,
  output logic [$clog2(MAX_PAGES)-1:0]          wdata
);

  localparam int TW = (TABLES > 1) ? $clog2(TABLES) : 1;
  localparam int PW = $clog2(MAX_PAGES);
  localparam int AW = $clog2(TABLES * MAX_PAGES);
  localparam logic [AW-1:0] MAXP = AW'(MAX_PAGES);

  logic [TW-1:0] tbl_r;
  logic [PW-1:0] cnt;
  logic [PW-1:0] first_r;
  logic [PW-1:0] last_r;

  // links a run of pages in descending order, the first one ends the list
  assign we    = busy;
  assign done  = busy && (cnt == last_r);
  assign waddr = AW'(tbl_r) * MAXP + AW'(cnt);
  assign wdata = (cnt == first_r) ? '0 : cnt - PW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy    <= 1'b1;
      tbl_r   <= tbl;
      cnt     <= first;
      first_r <= first;
      last_r  <= last;
    end else if (busy) begin
      if (cnt == last_r) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt + PW'(1);
      end
    end
  end

endmodule

[hw/rtl/page_free_list_allocator_unit.sv]
// per-table free page allocator: a lifo free list per table, page 0 ends the list
// s channel: one item asks to allocate (tuser kind 0) or free (kind 1) a page of a table
// m channel: one item per request, page number and free count in tdata, status in tuser
// free, bad and refused requests are answered from the execute state; a pop goes on
// to a read state, since it reads the link memory through its registered read port
// an allocate that finds the list empty doubles the table first, if twice its size fits
// MAX_PAGES, else it answers full; the fill unit writes one link per cycle
// one item is in work at a time; s_tready is high only while the sequencer is idle
// the result sits in an output register, so the next item is taken while it waits;
// if the receiver still holds the previous result, the sequencer waits to deliver
// after reset the fill unit rewrites the initial links of every table, one after another,
// and s_tready stays low during that sweep
module page_free_list_allocator_unit #(
  parameter int TABLES        = 4,
  parameter int MAX_PAGES     = 4096,
  parameter int INITIAL_PAGES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // page_in[11:0], zero pad
  input  logic [2:0]  s_tuser,   // kind[0], table_sel[2:1]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // page_out[11:0], free_pages[23:12]
  output logic [1:0]  m_tuser    // status[1:0]
);

  localparam int TW    = (TABLES > 1) ? $clog2(TABLES) : 1;
  localparam int PW    = $clog2(MAX_PAGES);
  localparam int CW    = PW + 1;
  localparam int AW    = $clog2(TABLES * MAX_PAGES);
  localparam int DEPTH = TABLES * MAX_PAGES;
  localparam int INIT  = (INITIAL_PAGES < MAX_PAGES) ? INITIAL_PAGES : MAX_PAGES;
  localparam int FW    = pfla_pkg::PAGE_FIELD_W;
  localparam int XW    = (CW > FW) ? CW : FW;
  localparam logic [AW-1:0] MAXP = AW'(MAX_PAGES);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_EXEC, S_GROW, S_RDW} state_t;

  state_t state;

  logic [PW-1:0] head  [TABLES];
  logic [CW-1:0] total [TABLES];
  logic [PW-1:0] freec [TABLES];

  logic          kind_r;
  logic          sel_ok_r;
  logic [TW-1:0] tbl_r;
  logic [FW-1:0] page_r;
  logic [TW-1:0] clr_tbl;

  logic [FW-1:0]       page_o;
  logic [FW-1:0]       free_o;
  pfla_pkg::status_t   status_o;

  logic [PW-1:0] cur_head;
  logic [CW-1:0] cur_total;
  logic [PW-1:0] cur_free;
  logic [CW:0]   dbl;
  logic          grow_ok;
  logic          bad_page;
  logic [PW-1:0] free_up;
  logic [PW-1:0] free_dn;
  logic          out_free;
  logic [PW-1:0] acc_page;
  logic [AW-1:0] acc_addr;
  logic          push_we;
  logic          rd_en;
  logic [PW-1:0] rd_data;
  logic          s_acc;

  logic          fill_start;
  logic [TW-1:0] fill_tbl;
  logic [PW-1:0] fill_first;
  logic [PW-1:0] fill_last;
  logic          fill_busy;
  logic          fill_done;
  logic          fill_we;
  logic [AW-1:0] fill_waddr;
  logic [PW-1:0] fill_wdata;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [PW-1:0] mem_wdata;

  assign s_tready = (state == S_IDLE);
  assign s_acc    = s_tvalid && s_tready;
  assign m_tdata  = {free_o, page_o};
  assign m_tuser  = status_o;
  assign out_free = !m_tvalid || m_tready;

  assign cur_head  = head[tbl_r];
  assign cur_total = total[tbl_r];
  assign cur_free  = freec[tbl_r];

  assign dbl      = {cur_total, 1'b0};
  assign grow_ok  = (dbl <= (CW + 1)'(MAX_PAGES));
  assign bad_page = (page_r == '0) || (XW'(page_r) >= XW'(cur_total));
  assign free_up  = (CW'(cur_free) < cur_total - CW'(1)) ? cur_free + PW'(1) : cur_free;
  assign free_dn  = (cur_free != '0) ? cur_free - PW'(1) : cur_free;

  // one address path serves the push write and the pop read
  assign acc_page = (kind_r == pfla_pkg::KIND_FREE) ? PW'(page_r) : cur_head;
  assign acc_addr = AW'(tbl_r) * MAXP + AW'(acc_page);

  assign push_we = (state == S_EXEC) && sel_ok_r && (kind_r == pfla_pkg::KIND_FREE)
                   && !bad_page && out_free;
  assign rd_en   = (state == S_EXEC) && sel_ok_r && (kind_r == pfla_pkg::KIND_ALLOC)
                   && (cur_head != '0);

  assign fill_start = ((state == S_CLEAR) && !fill_busy)
                      || ((state == S_EXEC) && sel_ok_r && (kind_r == pfla_pkg::KIND_ALLOC)
                          && (cur_head == '0) && grow_ok);
  assign fill_tbl   = (state == S_CLEAR) ? clr_tbl : tbl_r;
  assign fill_first = (state == S_CLEAR) ? '0 : PW'(cur_total);
  assign fill_last  = (state == S_CLEAR) ? PW'(INIT - 1) : PW'(dbl - (CW + 1)'(1));

  assign mem_we    = fill_we || push_we;
  assign mem_waddr = fill_we ? fill_waddr : acc_addr;
  assign mem_wdata = fill_we ? fill_wdata : cur_head;

  pfla_fill_unit #(
    .TABLES    (TABLES),
    .MAX_PAGES (MAX_PAGES)
  ) u_fill (
    .clk   (clk),
    .rst   (rst),
    .start (fill_start),
    .tbl   (fill_tbl),
    .first (fill_first),
    .last  (fill_last),
    .busy  (fill_busy),
    .done  (fill_done),
    .we    (fill_we),
    .waddr (fill_waddr),
    .wdata (fill_wdata)
  );

  pfla_link_mem #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (PW)
  ) u_links (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (rd_en),
    .raddr (acc_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_tbl  <= '0;
      m_tvalid <= 1'b0;
      for (int i = 0; i < TABLES; i++) begin
        head[i]  <= PW'(INIT - 1);
        total[i] <= CW'(INIT);
        freec[i] <= PW'(INIT - 1);
      end
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (fill_done) begin
            if (clr_tbl == TW'(TABLES - 1)) begin
              state <= S_IDLE;
            end else begin
              clr_tbl <= clr_tbl + TW'(1);
            end
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            kind_r   <= s_tuser[0];
            sel_ok_r <= (32'(s_tuser[2:1]) < TABLES);
            tbl_r    <= (32'(s_tuser[2:1]) < TABLES) ? TW'(s_tuser[2:1]) : '0;
            page_r   <= s_tdata[FW-1:0];
            state    <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (!sel_ok_r) begin
            if (out_free) begin
              m_tvalid <= 1'b1;
              page_o   <= '0;
              status_o <= pfla_pkg::STATUS_OK;
              free_o   <= '0;
              state    <= S_IDLE;
            end
          end else if (kind_r == pfla_pkg::KIND_FREE) begin
            if (out_free) begin
              m_tvalid <= 1'b1;
              page_o   <= '0;
              state    <= S_IDLE;
              if (bad_page) begin
                status_o <= pfla_pkg::STATUS_BAD_PAGE;
                free_o   <= FW'(cur_free);
              end else begin
                head[tbl_r]  <= PW'(page_r);
                freec[tbl_r] <= free_up;
                status_o     <= pfla_pkg::STATUS_OK;
                free_o       <= FW'(free_up);
              end
            end
          end else if (cur_head != '0) begin
            state <= S_RDW;
          end else if (grow_ok) begin
            state <= S_GROW;
          end else if (out_free) begin
            m_tvalid <= 1'b1;
            page_o   <= '0;
            status_o <= pfla_pkg::STATUS_FULL;
            free_o   <= FW'(cur_free);
            state    <= S_IDLE;
          end
        end
        S_GROW: begin
          if (fill_done) begin
            total[tbl_r] <= dbl[CW-1:0];
            head[tbl_r]  <= PW'(dbl - (CW + 1)'(1));
            freec[tbl_r] <= PW'(cur_total);
            state        <= S_EXEC;
          end
        end
        S_RDW: begin
          // read data holds while the receiver stalls, no new read is issued
          if (out_free) begin
            head[tbl_r]  <= rd_data;
            freec[tbl_r] <= free_dn;
            m_tvalid     <= 1'b1;
            page_o       <= FW'(cur_head);
            status_o     <= pfla_pkg::STATUS_OK;
            free_o       <= FW'(free_dn);
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    !(fill_we && push_we))
    else $error("link memory written by fill and push together");

  a_fill_in_place: assert property (@(posedge clk) disable iff (rst)
    fill_busy |-> (state == S_CLEAR || state == S_GROW))
    else $error("fill unit busy outside clear or grow");

  a_accept_blocks: assert property (@(posedge clk) disable iff (rst)
    s_acc |=> !s_tready)
    else $error("second item taken while one is in work");

  a_pop_after_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_RDW) |-> ($past(rd_en) || $past(state == S_RDW)))
    else $error("pop without a link read");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state == S_EXEC) || $past(state == S_RDW)))
    else $error("result raised outside execute or pop");

endmodule
